// ===== hdl/lob_pkg.sv =====
// Package for the limit order book engine: sizes, opcodes and sequencer states.
// No dependencies.
package lob_pkg;

    localparam int PRICE_TICKS = 4096;
    localparam int ORDER_SLOTS = 1024;
    localparam int MAX_DEPTH   = 16;
    localparam int PW          = $clog2(PRICE_TICKS);
    localparam int IW          = $clog2(ORDER_SLOTS);
    localparam int CW          = $clog2(ORDER_SLOTS + 1);
    localparam int LCW         = $clog2(PRICE_TICKS + 1);
    localparam int QW          = 32;
    localparam int TW          = 48;
    localparam int AW          = 40;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_CANCEL = 3'd1,
        OP_MODIFY = 3'd2,
        OP_QUEUE  = 3'd3,
        OP_DEPTH  = 3'd4
    } opcode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT_RD,
        ST_SLOT_WAIT,
        ST_LVL_RD,
        ST_LVL_WAIT,
        ST_UPDATE,
        ST_QSCAN,
        ST_QDONE,
        ST_DSCAN,
        ST_STAT,
        ST_EMIT
    } state_t;

endpackage

// ===== hdl/limit_order_book_engine.sv =====
// Limit order book engine top level: sequencer, level and slot memories.
// Depends on lob_pkg.
//
// One item at a time. After reset a clearing pass over every price tick zeroes
// the level memories and the slot live flags; no item is accepted meanwhile.
// Each item then does its slot and level reads and update, then one walk of the
// level memories that recomputes best bid, best ask, level count and collects
// depth levels; queue info first walks all order slots. Results go out one per
// cycle from an output register while m_ready is high.
module limit_order_book_engine (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_opcode,
    input  logic [9:0]               s_order_id,
    input  logic                     s_side,
    input  logic [11:0]              s_price,
    input  logic [31:0]              s_quantity,
    input  logic                     s_is_limit,
    input  logic [4:0]               s_depth_levels,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_ok,
    output logic                     m_last,
    output logic [11:0]              m_level_price,
    output logic [47:0]              m_level_qty,
    output logic [10:0]              m_level_orders,
    output logic [31:0]              m_own_qty,
    output logic [9:0]               m_queue_position,
    output logic [47:0]              m_vol_front,
    output logic [47:0]              m_vol_rear,
    output logic signed [12:0]       m_top_bid,
    output logic signed [12:0]       m_top_ask,
    output logic [12:0]              m_side_level_count
);
    import lob_pkg::*;

    localparam int DIW = $clog2(MAX_DEPTH);
    localparam int DCW = $clog2(MAX_DEPTH + 1);
    localparam int SW  = 2 + PW + QW + AW;

    // level memories: {total, live} per side
    logic [TW+CW-1:0] bid_mem [PRICE_TICKS];
    logic [TW+CW-1:0] ask_mem [PRICE_TICKS];
    // slot memory: {live, side, price, qty, arrival}
    logic [SW-1:0] slot_mem [ORDER_SLOTS];

    logic [TW+CW-1:0] bid_rd_reg, ask_rd_reg;
    logic [SW-1:0] slot_rd_reg;

    state_t state_reg, state_next;

    // latched item
    opcode_t     op_reg;
    logic [IW-1:0] id_reg;
    logic        side_reg;
    logic [PW-1:0] price_reg;
    logic [QW-1:0] qty_reg;
    logic        lim_reg;
    logic [4:0]  want_reg;

    logic        ok_reg, ok_next;
    logic [AW-1:0] arr_reg;

    // scan
    logic [LCW-1:0] ptr_reg, ptr_next;
    logic           pv_reg;          // data for previous address is in rd regs
    logic [PW-1:0]  pp_reg;
    logic signed [12:0] bb_reg, ba_reg;
    logic [12:0]    cnt_reg;
    logic [DCW-1:0] nd_reg, ne_reg;
    logic [DCW-1:0] lim_n;

    // depth buffer (one register per result row)
    logic [PW-1:0] dp_reg [MAX_DEPTH];
    logic [TW-1:0] dq_reg [MAX_DEPTH];
    logic [CW-1:0] dn_reg [MAX_DEPTH];

    // queue info accumulators
    logic [IW-1:0] pos_reg;
    logic [TW-1:0] ahead_reg, behind_reg, lvq_reg;
    logic [QW-1:0] own_reg;
    logic          own_side_reg;
    logic [PW-1:0] own_price_reg;
    logic [AW-1:0] own_arr_reg;

    // output register
    logic out_v_reg;

    // slot fields
    logic          sl_live;
    logic          sl_side;
    logic [PW-1:0] sl_price;
    logic [QW-1:0] sl_qty;
    logic [AW-1:0] sl_arr;
    assign {sl_live, sl_side, sl_price, sl_qty, sl_arr} = slot_rd_reg;

    logic [TW-1:0] bid_tot, ask_tot;
    logic [CW-1:0] bid_live, ask_live;
    assign {bid_tot, bid_live} = bid_rd_reg;
    assign {ask_tot, ask_live} = ask_rd_reg;

    // memory address / write control
    logic [PW-1:0] lvl_addr;
    logic          lvl_we_bid, lvl_we_ask;
    logic [TW+CW-1:0] lvl_wd;
    logic [IW-1:0] slot_addr;
    logic          slot_we;
    logic [SW-1:0] slot_wd;

    always_ff @(posedge aclk) begin
        if (lvl_we_bid) bid_mem[lvl_addr] <= lvl_wd;
        if (lvl_we_ask) ask_mem[lvl_addr] <= lvl_wd;
        bid_rd_reg <= bid_mem[lvl_addr];
        ask_rd_reg <= ask_mem[lvl_addr];
        if (slot_we) slot_mem[slot_addr] <= slot_wd;
        slot_rd_reg <= slot_mem[slot_addr];
    end

    assign lim_n = (want_reg > 5'(MAX_DEPTH)) ? DCW'(MAX_DEPTH) : DCW'(want_reg);

    logic s_fire, m_fire;
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = out_v_reg && m_ready;

    logic [PW-1:0] scan_p;   // price of current scan index
    assign scan_p = op_reg == OP_DEPTH && side_reg == 1'b0
                    ? PW'(PRICE_TICKS - 1) - ptr_reg[PW-1:0] : ptr_reg[PW-1:0];

    logic eff_side;
    assign eff_side = (op_reg == OP_ADD) ? side_reg : sl_side;
    logic [PW-1:0] eff_price;
    assign eff_price = (op_reg == OP_ADD) ? price_reg : sl_price;
    logic [TW-1:0] cur_tot;
    logic [CW-1:0] cur_live;
    assign cur_tot  = eff_side ? ask_tot : bid_tot;
    assign cur_live = eff_side ? ask_live : bid_live;
    logic is_cancel;
    assign is_cancel = op_reg == OP_CANCEL || (op_reg == OP_MODIFY && qty_reg == '0);
    logic live_id;
    assign live_id = sl_live;

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        ok_next    = ok_reg;
        lvl_addr   = price_reg;
        lvl_we_bid = 1'b0;
        lvl_we_ask = 1'b0;
        lvl_wd     = '0;
        slot_addr  = id_reg;
        slot_we    = 1'b0;
        slot_wd    = {1'b1, side_reg, price_reg, qty_reg, arr_reg};
        unique case (state_reg)
            ST_CLEAR: begin
                lvl_addr   = ptr_reg[PW-1:0];
                lvl_we_bid = 1'b1;
                lvl_we_ask = 1'b1;
                slot_addr  = ptr_reg[IW-1:0];
                slot_we    = ptr_reg < LCW'(ORDER_SLOTS);
                slot_wd    = '0;
                ptr_next   = ptr_reg + 1'b1;
                if (ptr_reg == LCW'(PRICE_TICKS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                slot_addr = s_order_id;
                if (s_fire) state_next = ST_SLOT_RD;
            end
            ST_SLOT_RD: state_next = ST_SLOT_WAIT;
            ST_SLOT_WAIT: begin
                lvl_addr = eff_price;
                state_next = ST_LVL_RD;
            end
            ST_LVL_RD: begin
                lvl_addr = eff_price;
                state_next = ST_LVL_WAIT;
            end
            ST_LVL_WAIT: begin
                lvl_addr = eff_price;
                // accept/reject decision; best prices are current in bb/ba
                unique case (op_reg)
                    OP_ADD: ok_next = lim_reg && qty_reg != '0 && !live_id &&
                        !(side_reg == 1'b0 && ba_reg >= 0 &&
                          $signed({1'b0, price_reg}) >= ba_reg) &&
                        !(side_reg == 1'b1 && bb_reg >= 0 &&
                          $signed({1'b0, price_reg}) <= bb_reg);
                    OP_CANCEL, OP_MODIFY: ok_next = is_cancel ? live_id :
                        (live_id && qty_reg <= sl_qty);
                    OP_QUEUE: ok_next = live_id;
                    default: ok_next = 1'b0;
                endcase
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                lvl_addr = eff_price;
                if (ok_reg && op_reg == OP_ADD) begin
                    lvl_wd = {cur_tot + TW'(qty_reg), cur_live + 1'b1};
                    slot_we = 1'b1;
                end else if (ok_reg && is_cancel) begin
                    lvl_wd = {cur_tot - TW'(sl_qty), cur_live - 1'b1};
                    slot_wd = {1'b0, sl_side, sl_price, sl_qty, sl_arr};
                    slot_we = 1'b1;
                end else begin
                    lvl_wd = {cur_tot - TW'(sl_qty - qty_reg), cur_live};
                    if (ok_reg && op_reg == OP_MODIFY)
                        slot_wd = {1'b1, sl_side, sl_price, qty_reg, sl_arr};
                    slot_we = ok_reg && op_reg == OP_MODIFY;
                end
                if (ok_reg && (op_reg == OP_ADD || op_reg == OP_CANCEL ||
                               op_reg == OP_MODIFY)) begin
                    lvl_we_bid = !eff_side;
                    lvl_we_ask = eff_side;
                end
                ptr_next = '0;
                state_next = (ok_reg && op_reg == OP_QUEUE) ? ST_QSCAN : ST_DSCAN;
            end
            ST_QSCAN: begin
                slot_addr = ptr_reg[IW-1:0];
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LCW'(ORDER_SLOTS)) begin
                    ptr_next = '0;
                    state_next = ST_DSCAN;
                end
            end
            ST_DSCAN: begin
                lvl_addr = scan_p;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LCW'(PRICE_TICKS)) state_next = ST_STAT;
            end
            ST_STAT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_fire && m_last) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic [IW-1:0] qidx;     // slot data in slot_rd_reg is for index ptr_reg-1
    assign qidx = IW'(ptr_reg - 1'b1);

    logic [TW-1:0] row_tot;
    logic [CW-1:0] row_live, row_bl, row_al;
    assign row_tot = side_reg ? ask_tot : bid_tot;
    assign row_live = side_reg ? ask_live : bid_live;
    assign row_bl = bid_live;
    assign row_al = ask_live;

    logic [DCW-1:0] nrows;
    assign nrows = (nd_reg == '0) ? DCW'(1) : nd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ptr_reg   <= '0;
            arr_reg   <= '0;
            bb_reg    <= -13'sd1;
            ba_reg    <= -13'sd1;
            out_v_reg <= 1'b0;
            ok_reg    <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            ok_reg    <= ok_next;
            if (s_fire) begin
                op_reg    <= opcode_t'(s_opcode);
                id_reg    <= s_order_id;
                side_reg  <= s_side;
                price_reg <= s_price;
                qty_reg   <= s_quantity;
                lim_reg   <= s_is_limit;
                want_reg  <= s_depth_levels;
            end
            if (state_reg == ST_UPDATE) begin
                if (ok_reg && op_reg == OP_ADD) arr_reg <= arr_reg + 1'b1;
                own_side_reg  <= sl_side;
                own_price_reg <= sl_price;
                own_reg       <= sl_qty;
                own_arr_reg   <= sl_arr;
                lvq_reg       <= cur_tot;
                pos_reg <= '0; ahead_reg <= '0; behind_reg <= '0;
                pv_reg  <= 1'b0;
            end
            if (state_reg == ST_QSCAN) begin
                pv_reg <= (ptr_reg != LCW'(ORDER_SLOTS));
                if (pv_reg && qidx != id_reg && sl_live &&
                    sl_side == own_side_reg && sl_price == own_price_reg) begin
                    if (sl_arr < own_arr_reg) begin
                        pos_reg   <= pos_reg + 1'b1;
                        ahead_reg <= ahead_reg + TW'(sl_qty);
                    end else begin
                        behind_reg <= behind_reg + TW'(sl_qty);
                    end
                end
            end
            if (state_reg == ST_DSCAN) begin
                pv_reg <= 1'b1;
                pp_reg <= scan_p;
                if (!pv_reg) begin
                    bb_reg <= -13'sd1; ba_reg <= -13'sd1;
                    cnt_reg <= '0; nd_reg <= '0;
                end else begin
                    // scan runs ascending for bids unless depth on bid side
                    if (row_bl != '0 && (bb_reg < 0 ||
                        $signed({1'b0, pp_reg}) > bb_reg))
                        bb_reg <= $signed({1'b0, pp_reg});
                    if (row_al != '0 && (ba_reg < 0 ||
                        $signed({1'b0, pp_reg}) < ba_reg))
                        ba_reg <= $signed({1'b0, pp_reg});
                    if (row_live != '0) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (op_reg == OP_DEPTH && nd_reg < lim_n) begin
                            dp_reg[nd_reg[DIW-1:0]] <= pp_reg;
                            dq_reg[nd_reg[DIW-1:0]] <= row_tot;
                            dn_reg[nd_reg[DIW-1:0]] <= row_live;
                            nd_reg <= nd_reg + 1'b1;
                        end
                    end
                end
            end
            if (state_reg == ST_STAT) begin
                pv_reg <= 1'b0;
                ne_reg <= '0;
                out_v_reg <= 1'b1;
            end
            if (state_reg == ST_EMIT && m_fire) begin
                ne_reg <= ne_reg + 1'b1;
                if (m_last) out_v_reg <= 1'b0;
            end
        end
    end

    logic is_depth_row;
    assign is_depth_row = op_reg == OP_DEPTH && nd_reg != '0;
    logic [DIW-1:0] ei;
    assign ei = ne_reg[DIW-1:0];

    assign m_valid            = out_v_reg;
    assign m_last             = (ne_reg + 1'b1) == nrows;
    assign m_ok               = is_depth_row ? 1'b1 :
                                (op_reg == OP_DEPTH ? 1'b0 :
                                 (op_reg == OP_ADD || op_reg == OP_CANCEL ||
                                  op_reg == OP_MODIFY || op_reg == OP_QUEUE) && ok_reg);
    assign m_level_price      = is_depth_row ? dp_reg[ei] : '0;
    assign m_level_qty        = is_depth_row ? dq_reg[ei] :
                                (op_reg == OP_QUEUE && ok_reg ? lvq_reg : '0);
    assign m_level_orders     = is_depth_row ? dn_reg[ei] : '0;
    assign m_own_qty          = (op_reg == OP_QUEUE && ok_reg) ? own_reg : '0;
    assign m_queue_position   = (op_reg == OP_QUEUE && ok_reg) ? pos_reg : '0;
    assign m_vol_front        = (op_reg == OP_QUEUE && ok_reg) ? ahead_reg : '0;
    assign m_vol_rear         = (op_reg == OP_QUEUE && ok_reg) ? behind_reg : '0;
    assign m_top_bid          = bb_reg;
    assign m_top_ask          = ba_reg;
    assign m_side_level_count = cnt_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input taken while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_v_reg |-> (state_reg == ST_EMIT || state_reg == ST_STAT))
        else $error("result outside emit phase");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last) |=> !m_valid)
        else $error("result after last");

endmodule

// ===== sim/tb_limit_order_book_engine.sv =====
// Testbench for limit_order_book_engine: directed and random order-book traffic,
// results checked against a behavioral book kept here. Depends on lob_pkg and the RTL.
`timescale 1ns / 1ps

module tb_limit_order_book_engine;
    import lob_pkg::*;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [9:0]  order_id;
        logic        side;
        logic [11:0] price;
        logic [31:0] quantity;
        logic        is_limit;
        logic [4:0]  depth_levels;
    } order_req_t;

    typedef struct packed {
        logic               ok;
        logic               last;
        logic [11:0]        level_price;
        logic [47:0]        level_qty;
        logic [10:0]        level_orders;
        logic [31:0]        own_qty;
        logic [9:0]         queue_position;
        logic [47:0]        vol_front;
        logic [47:0]        vol_rear;
        logic signed [12:0] top_bid;
        logic signed [12:0] top_ask;
        logic [12:0]        side_level_count;
    } book_rsp_t;

    localparam int WATCHDOG = 200000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_opcode = '0;
    logic [9:0] s_order_id = '0;
    logic s_side = 1'b0;
    logic [11:0] s_price = '0;
    logic [31:0] s_quantity = '0;
    logic s_is_limit = 1'b0;
    logic [4:0] s_depth_levels = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_ok, m_last;
    logic [11:0] m_level_price;
    logic [47:0] m_level_qty;
    logic [10:0] m_level_orders;
    logic [31:0] m_own_qty;
    logic [9:0] m_queue_position;
    logic [47:0] m_vol_front, m_vol_rear;
    logic signed [12:0] m_top_bid, m_top_ask;
    logic [12:0] m_side_level_count;

    always #2 aclk = ~aclk;

    limit_order_book_engine u_top (.*);

    // shadow book
    logic [47:0] bid_total [PRICE_TICKS];
    logic [10:0] bid_live [PRICE_TICKS];
    logic [47:0] ask_total [PRICE_TICKS];
    logic [10:0] ask_live [PRICE_TICKS];
    logic        ord_live [ORDER_SLOTS];
    logic        ord_side [ORDER_SLOTS];
    logic [11:0] ord_price [ORDER_SLOTS];
    logic [31:0] ord_qty [ORDER_SLOTS];
    logic [39:0] ord_stamp [ORDER_SLOTS];
    logic [39:0] stamp_ctr;

    order_req_t pending_orders[$];
    book_rsp_t  expected_rsps[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_sender = 0;
    bit  no_idle = 0;
    int  sink_hold = 0;

    function automatic int top_bid_tick();
        for (int p = PRICE_TICKS - 1; p >= 0; p--) if (bid_live[p] != 0) return p;
        return -1;
    endfunction

    function automatic int top_ask_tick();
        for (int p = 0; p < PRICE_TICKS; p++) if (ask_live[p] != 0) return p;
        return -1;
    endfunction

    function automatic void queue_item(order_req_t r);
        pending_orders.insert(pending_orders.size(), r);
    endfunction

    function automatic void unbook(int id);
        int p;
        p = ord_price[id];
        if (ord_side[id]) begin
            ask_total[p] -= ord_qty[id];
            ask_live[p]--;
        end else begin
            bid_total[p] -= ord_qty[id];
            bid_live[p]--;
        end
        ord_live[id] = 0;
    endfunction

    // apply one request to the shadow book and queue its results
    function automatic void predict_book(order_req_t r);
        book_rsp_t rs[$];
        book_rsp_t z;
        int id, bb, ba, cnt, p, lim_n;
        logic [47:0] ahead, behind, d;
        logic [9:0] pos;
        bit okv;
        id = r.order_id;
        z = '{default: '0};
        case (r.opcode)
            OP_ADD: begin
                okv = r.is_limit && r.quantity != 0 && !ord_live[id];
                if (okv && r.side == 0) begin
                    ba = top_ask_tick();
                    if (ba >= 0 && int'(r.price) >= ba) okv = 0;
                end else if (okv) begin
                    bb = top_bid_tick();
                    if (bb >= 0 && int'(r.price) <= bb) okv = 0;
                end
                if (okv) begin
                    ord_live[id] = 1;
                    ord_side[id] = r.side;
                    ord_price[id] = r.price;
                    ord_qty[id] = r.quantity;
                    ord_stamp[id] = stamp_ctr;
                    stamp_ctr++;
                    if (r.side) begin
                        ask_total[r.price] += r.quantity;
                        ask_live[r.price]++;
                    end else begin
                        bid_total[r.price] += r.quantity;
                        bid_live[r.price]++;
                    end
                end
                z.ok = okv;
                rs.insert(rs.size(), z);
            end
            OP_CANCEL, OP_MODIFY: begin
                if (r.opcode == OP_CANCEL || r.quantity == 0) begin
                    z.ok = ord_live[id];
                    if (ord_live[id]) unbook(id);
                end else begin
                    okv = ord_live[id] && r.quantity <= ord_qty[id];
                    if (okv) begin
                        d = 48'(ord_qty[id] - r.quantity);
                        p = ord_price[id];
                        if (ord_side[id]) ask_total[p] -= d;
                        else bid_total[p] -= d;
                        ord_qty[id] = r.quantity;
                    end
                    z.ok = okv;
                end
                rs.insert(rs.size(), z);
            end
            OP_QUEUE: begin
                if (ord_live[id]) begin
                    ahead = 0;
                    behind = 0;
                    pos = 0;
                    p = ord_price[id];
                    for (int j = 0; j < ORDER_SLOTS; j++) begin
                        if (j == id || !ord_live[j] || ord_side[j] != ord_side[id] ||
                            ord_price[j] != ord_price[id]) continue;
                        if (ord_stamp[j] < ord_stamp[id]) begin
                            pos++;
                            ahead += ord_qty[j];
                        end else begin
                            behind += ord_qty[j];
                        end
                    end
                    z.ok = 1;
                    z.level_qty = ord_side[id] ? ask_total[p] : bid_total[p];
                    z.own_qty = ord_qty[id];
                    z.queue_position = pos;
                    z.vol_front = ahead;
                    z.vol_rear = behind;
                end
                rs.insert(rs.size(), z);
            end
            OP_DEPTH: begin
                lim_n = r.depth_levels < MAX_DEPTH ? r.depth_levels : MAX_DEPTH;
                p = r.side ? 0 : PRICE_TICKS - 1;
                while (rs.size() < lim_n && p >= 0 && p < PRICE_TICKS) begin
                    if ((r.side ? ask_live[p] : bid_live[p]) != 0) begin
                        z.ok = 1;
                        z.level_price = 12'(p);
                        z.level_qty = r.side ? ask_total[p] : bid_total[p];
                        z.level_orders = r.side ? ask_live[p] : bid_live[p];
                        rs.insert(rs.size(), z);
                    end
                    p += r.side ? 1 : -1;
                end
                if (rs.size() == 0) begin
                    z = '{default: '0};
                    rs.insert(rs.size(), z);
                end
            end
            default: rs.insert(rs.size(), z);
        endcase
        bb = top_bid_tick();
        ba = top_ask_tick();
        cnt = 0;
        for (int q = 0; q < PRICE_TICKS; q++)
            if ((r.side ? ask_live[q] : bid_live[q]) != 0) cnt++;
        foreach (rs[k]) begin
            rs[k].last = (k == rs.size() - 1);
            rs[k].top_bid = 13'(bb);
            rs[k].top_ask = 13'(ba);
            rs[k].side_level_count = 13'(cnt);
            expected_rsps.insert(expected_rsps.size(), rs[k]);
        end
    endfunction

    function automatic order_req_t mk(logic [2:0] op, int id, bit sd, int pr,
                                      logic [31:0] q, bit lim, int dl);
        order_req_t r;
        r.opcode = op;
        r.order_id = 10'(id);
        r.side = sd;
        r.price = 12'(pr);
        r.quantity = q;
        r.is_limit = lim;
        r.depth_levels = 5'(dl);
        return r;
    endfunction

    // random item, mostly well formed around a mid price with a small id pool
    function automatic order_req_t rand_req();
        order_req_t r;
        int sel, id;
        bit sd;
        sel = $urandom_range(0, 99);
        id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 47);
        sd = 1'($urandom_range(0, 1));
        if (sel < 45) begin
            r = mk(OP_ADD, id, sd,
                   sd ? $urandom_range(2050, 2070) : $urandom_range(2025, 2045),
                   $urandom_range(1, 1000), 1, 0);
            if ($urandom_range(0, 15) == 0) r.quantity = $urandom;
            if ($urandom_range(0, 15) == 0) r.price = 12'($urandom_range(0, 4095));
            if ($urandom_range(0, 19) == 0) r.is_limit = 0;
        end else if (sel < 55) begin
            r = mk(OP_CANCEL, id, sd, 0, 0, 0, 0);
        end else if (sel < 70) begin
            r = mk(OP_MODIFY, id, sd, 0, $urandom_range(0, 1200), 0, 0);
        end else if (sel < 82) begin
            r = mk(OP_QUEUE, id, sd, 0, 0, 0, 0);
        end else if (sel < 94) begin
            r = mk(OP_DEPTH, id, sd, 0, 0, 0, $urandom_range(0, 31));
        end else begin
            r = mk(3'($urandom_range(5, 7)), $urandom_range(0, 1023), sd,
                   $urandom_range(0, 4095), $urandom, 1'($urandom_range(0, 1)),
                   $urandom_range(0, 31));
        end
        // stray bits in unused fields still exercise every input bit
        if (r.opcode != OP_ADD && $urandom_range(0, 3) == 0) begin
            r.price = 12'($urandom_range(0, 4095));
            r.is_limit = 1'($urandom_range(0, 1));
            r.depth_levels = r.opcode == OP_DEPTH ? r.depth_levels :
                             5'($urandom_range(0, 31));
        end
        return r;
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_book('{s_opcode, s_order_id, s_side, s_price, s_quantity,
                               s_is_limit, s_depth_levels});
            end
            if (pending_orders.size() > 0 && !hold_sender &&
                (no_idle || $urandom_range(0, 99) >= 18)) begin
                order_req_t r;
                r = pending_orders.pop_front();
                s_valid <= 1'b1;
                s_opcode <= r.opcode;
                s_order_id <= r.order_id;
                s_side <= r.side;
                s_price <= r.price;
                s_quantity <= r.quantity;
                s_is_limit <= r.is_limit;
                s_depth_levels <= r.depth_levels;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            book_rsp_t e;
            book_rsp_t a;
            a = '{m_ok, m_last, m_level_price, m_level_qty, m_level_orders, m_own_qty,
                  m_queue_position, m_vol_front, m_vol_rear, m_top_bid, m_top_ask,
                  m_side_level_count};
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected result transfer %p", $time, a);
                errors++;
            end else begin
                e = expected_rsps.pop_front();
                if (a !== e) begin
                    $display("%0t: mismatch expected %p", $time, e);
                    $display("%0t:          actual   %p", $time, a);
                    errors++;
                end
            end
        end
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (no_idle || $urandom_range(0, 99) >= 18);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic drain();
        wait (pending_orders.size() == 0);
        @(posedge aclk);
        while (s_valid || expected_rsps.size() > 0) @(posedge aclk);
    endtask

    initial begin
        for (int p = 0; p < PRICE_TICKS; p++) begin
            bid_total[p] = 0;
            bid_live[p] = 0;
            ask_total[p] = 0;
            ask_live[p] = 0;
        end
        for (int i = 0; i < ORDER_SLOTS; i++) begin
            ord_live[i] = 0;
            ord_side[i] = 0;
            ord_price[i] = 0;
            ord_qty[i] = 0;
            ord_stamp[i] = 0;
        end
        stamp_ctr = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, rejects, queue order, modify cases, depth edges
        queue_item(mk(OP_DEPTH, 0, 0, 0, 0, 0, 5));
        queue_item(mk(OP_ADD, 0, 0, 0, 32'hFFFF_FFFF, 1, 0));
        queue_item(mk(OP_ADD, 1023, 1, 4095, 32'hFFFF_FFFF, 1, 0));
        queue_item(mk(OP_ADD, 1, 0, 0, 32'hFFFF_FFFF, 1, 0));
        queue_item(mk(OP_ADD, 2, 0, 0, 7, 1, 0));
        queue_item(mk(OP_ADD, 3, 0, 100, 0, 1, 0));
        queue_item(mk(OP_ADD, 3, 0, 100, 9, 0, 0));
        queue_item(mk(OP_ADD, 0, 1, 200, 9, 1, 0));
        queue_item(mk(OP_ADD, 4, 0, 4095, 9, 1, 0));
        queue_item(mk(OP_ADD, 5, 1, 0, 9, 1, 0));
        queue_item(mk(OP_ADD, 6, 1, 300, 50, 1, 0));
        queue_item(mk(OP_QUEUE, 1, 0, 0, 0, 0, 0));
        queue_item(mk(OP_QUEUE, 900, 0, 0, 0, 0, 0));
        queue_item(mk(OP_MODIFY, 2, 0, 0, 8, 0, 0));
        queue_item(mk(OP_MODIFY, 2, 0, 0, 7, 0, 0));
        queue_item(mk(OP_MODIFY, 2, 0, 0, 3, 0, 0));
        queue_item(mk(OP_QUEUE, 2, 0, 0, 0, 0, 0));
        queue_item(mk(OP_MODIFY, 1, 0, 0, 0, 0, 0));
        queue_item(mk(OP_CANCEL, 1, 0, 0, 0, 0, 0));
        queue_item(mk(OP_DEPTH, 0, 1, 0, 0, 0, 31));
        queue_item(mk(OP_DEPTH, 0, 0, 0, 0, 0, 0));
        queue_item(mk(3'd7, 1023, 1, 4095, 32'hFFFF_FFFF, 1, 31));
        queue_item(mk(OP_CANCEL, 0, 0, 0, 0, 0, 0));
        queue_item(mk(OP_CANCEL, 1023, 0, 0, 0, 0, 0));
        drain();

        // fill the book at many levels while the receiver holds off past one item time
        no_idle = 1;
        sink_hold = 6000;
        for (int i = 0; i < 20; i++)
            queue_item(mk(OP_ADD, 100 + i, i % 2,
                i % 2 ? 2100 + i : 2000 - i, $urandom_range(1, 500), 1, 0));
        queue_item(mk(OP_DEPTH, 0, 0, 0, 0, 0, 16));
        queue_item(mk(OP_DEPTH, 0, 1, 0, 0, 0, 20));
        drain();
        no_idle = 0;

        for (int i = 0; i < 96; i++) begin
            queue_item(rand_req());
            if (i == 60) begin
                drain();
                hold_sender = 1;
                repeat (20) @(posedge aclk);
                hold_sender = 0;
            end
        end
        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
